// ----- rtl/dtfp_pkg.sv -----
// dtfp_pkg: shared types and constants of the decimal text field parser
// used by dtfp_front, dtfp_back and decimal_text_field_parser; no dependencies
package dtfp_pkg;

	localparam int ACC_W = 27;
	localparam int FRAC_W = 7;
	localparam int CNT_W = 4;
	localparam int VALUE_W = 24;
	localparam int MONEY_W = 24;
	localparam int VOL_W = 17;
	localparam int CFG_DATA_W = 24;

	// field kinds
	typedef enum logic [1:0] {
		MODE_PRICE  = 2'd0,
		MODE_MONEY  = 2'd1,
		MODE_VOLUME = 2'd2,
		MODE_PIN    = 2'd3
	} mode_t;

	// configuration register indexes
	localparam logic REG_MONEY_LIMIT = 1'b0;
	localparam logic REG_VOLUME_LIMIT = 1'b1;

	localparam logic [MONEY_W-1:0] MONEY_LIMIT_RST = 24'd999999;
	localparam logic [VOL_W-1:0] VOLUME_LIMIT_RST = 17'd90099;

	localparam logic [7:0] ASCII_ZERO = 8'h30;
	localparam logic [7:0] ASCII_NINE = 8'h39;
	localparam logic [7:0] ASCII_DOT = 8'h2E;

	localparam logic [13:0] PRICE_MAX = 14'd9999;
	localparam logic [9:0] LITERS_MAX = 10'd900;
	localparam logic [6:0] CL_PER_LITER = 7'd100;
	localparam logic [CNT_W-1:0] FRAC_DIGITS_MAX = 4'd2;
	localparam logic [CNT_W-1:0] PIN_MAX = 4'd8;
	localparam logic [CNT_W-1:0] PIN_MIN = 4'd4;
	localparam logic [CNT_W-1:0] PRICE_DIGITS_MAX = 4'd4;
	localparam logic [CNT_W-1:0] CNT_SAT = 4'd15;

	// classified character request
	typedef struct packed {
		mode_t      mode;
		logic       eot;
		logic       is_digit;
		logic       is_dot;
		logic [3:0] digit;
	} item_t;

	// finished result
	typedef struct packed {
		logic               ok;
		logic [VALUE_W-1:0] value;
	} result_t;

	// limit registers
	typedef struct packed {
		logic [MONEY_W-1:0] money_limit;
		logic [VOL_W-1:0]   volume_limit_cl;
	} cfg_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v < CNT_SAT) ? v + 1'b1 : CNT_SAT;
	endfunction

endpackage

// ----- rtl/dtfp_front.sv -----
// dtfp_front: accepts characters, classifies them, and holds them in a
// two-entry queue for the back end; depends on dtfp_pkg
module dtfp_front import dtfp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic [1:0] mode,
	input  logic [7:0] char_code,
	input  logic       end_of_text,
	output logic       full,
	output logic       mid_valid,
	output item_t      mid_item,
	input  logic       mid_pop
);

	item_t      item_in;
	item_t      slot_q [2];
	logic [1:0] cnt_q;
	logic       wr_q;
	logic       rd_q;
	logic       do_push;
	logic       do_pop;

	always_comb begin
		item_in.mode = mode_t'(mode);
		item_in.eot = end_of_text;
		item_in.is_digit = (char_code >= ASCII_ZERO) && (char_code <= ASCII_NINE);
		item_in.is_dot = (char_code == ASCII_DOT);
		item_in.digit = item_in.is_digit ? 4'(char_code - ASCII_ZERO) : 4'd0;
	end

	assign full = (cnt_q == 2'd2);
	assign mid_valid = (cnt_q != 2'd0);
	assign mid_item = slot_q[rd_q];
	assign do_push = push && !full;
	assign do_pop = mid_pop && mid_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wr_q <= 1'b0;
			rd_q <= 1'b0;
		end else begin
			if (do_push) begin
				wr_q <= !wr_q;
			end
			if (do_pop) begin
				rd_q <= !rd_q;
			end
			case ({do_push, do_pop})
				2'b10: cnt_q <= cnt_q + 2'd1;
				2'b01: cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ----- rtl/dtfp_back.sv -----
// dtfp_back: running parse state, end-of-text checks and the result queue
// depends on dtfp_pkg; fed by dtfp_front
module dtfp_back import dtfp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               mid_valid,
	input  item_t              mid_item,
	output logic               mid_pop,
	output logic               empty,
	input  logic               pop,
	output logic               text_ok,
	output logic [VALUE_W-1:0] field_value
);

	logic [ACC_W-1:0]  acc_q, acc_n;
	logic [FRAC_W-1:0] frac_q, frac_n;
	logic [CNT_W-1:0]  td_q, td_n;
	logic [CNT_W-1:0]  dbp_q, dbp_n;
	logic [CNT_W-1:0]  dap_q, dap_n;
	logic              point_q, point_n;
	logic              rej_q, rej_n;
	logic              digit_ok;

	logic [ACC_W+3:0]  acc_next;
	logic [10:0]       frac_next;
	logic [10:0]       vol_frac;
	logic [ACC_W+7:0]  vol_value;
	logic              fin_ok;
	logic [VALUE_W-1:0] fin_value;
	result_t           res_in;

	result_t           res_q [2];
	logic [1:0]        res_cnt_q;
	logic              res_wr_q;
	logic              res_rd_q;
	logic              res_full;
	logic              take;
	logic              res_push;
	logic              res_pop;

	assign res_full = (res_cnt_q == 2'd2);
	assign take = mid_valid && (!mid_item.eot || !res_full);
	assign mid_pop = take;
	assign res_push = take && mid_item.eot;
	assign res_pop = pop && !empty;

	// acc * 10 + digit, kept wide for the limit compares
	assign acc_next = {acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + (ACC_W+4)'(mid_item.digit);
	assign frac_next = {frac_q, 3'b000} + {3'b000, frac_q, 1'b0} + 11'(mid_item.digit);

	always_comb begin
		acc_n = acc_q;
		frac_n = frac_q;
		td_n = td_q;
		dbp_n = dbp_q;
		dap_n = dap_q;
		point_n = point_q;
		rej_n = rej_q;
		digit_ok = 1'b1;
		if (take) begin
			if (mid_item.eot) begin
				acc_n = '0;
				frac_n = '0;
				td_n = '0;
				dbp_n = '0;
				dap_n = '0;
				point_n = 1'b0;
				rej_n = 1'b0;
			end else if (!rej_q) begin
				if (!mid_item.is_digit) begin
					if (mid_item.is_dot && !point_q &&
					    (mid_item.mode == MODE_PRICE || mid_item.mode == MODE_VOLUME)) begin
						point_n = 1'b1;
					end else begin
						rej_n = 1'b1;
					end
				end else begin
					case (mid_item.mode)
						MODE_PRICE: begin
							if (td_q >= PRICE_DIGITS_MAX) digit_ok = 1'b0;
							else acc_n = acc_next[ACC_W-1:0];
						end
						MODE_MONEY: begin
							if (acc_next > (ACC_W+4)'(cfg.money_limit)) digit_ok = 1'b0;
							else acc_n = acc_next[ACC_W-1:0];
						end
						MODE_VOLUME: begin
							if (!point_q) begin
								if (acc_next > (ACC_W+4)'(LITERS_MAX)) digit_ok = 1'b0;
								else acc_n = acc_next[ACC_W-1:0];
							end else begin
								if (dap_q >= FRAC_DIGITS_MAX) digit_ok = 1'b0;
								else frac_n = frac_next[FRAC_W-1:0];
							end
						end
						default: begin
							if (td_q >= PIN_MAX) digit_ok = 1'b0;
						end
					endcase
					if (!digit_ok) begin
						rej_n = 1'b1;
					end else begin
						td_n = sat_inc(td_q);
						if (point_q) dap_n = sat_inc(dap_q);
						else dbp_n = sat_inc(dbp_q);
					end
				end
			end
		end
	end

	// end-of-text evaluation on the current state
	assign vol_frac = (dap_q == 4'd1) ? {frac_q, 3'b000} + {3'b000, frac_q, 1'b0}
	                                  : 11'(frac_q);
	assign vol_value = (ACC_W+8)'(acc_q) * (ACC_W+8)'(CL_PER_LITER) + (ACC_W+8)'(vol_frac);

	always_comb begin
		fin_ok = !rej_q;
		fin_value = '0;
		case (mid_item.mode)
			MODE_PRICE: begin
				if (dbp_q == '0) fin_ok = 1'b0;
				if (point_q && (dap_q == '0 || dap_q > FRAC_DIGITS_MAX)) fin_ok = 1'b0;
				if (acc_q == '0 || acc_q > ACC_W'(PRICE_MAX)) fin_ok = 1'b0;
				fin_value = acc_q[VALUE_W-1:0];
			end
			MODE_MONEY: begin
				if (acc_q > ACC_W'(cfg.money_limit)) fin_ok = 1'b0;
				fin_value = acc_q[VALUE_W-1:0];
			end
			MODE_VOLUME: begin
				if (point_q && dap_q == '0) fin_ok = 1'b0;
				if (vol_value > (ACC_W+8)'(cfg.volume_limit_cl)) fin_ok = 1'b0;
				fin_value = vol_value[VALUE_W-1:0];
			end
			default: begin
				if (td_q < PIN_MIN || td_q > PIN_MAX) fin_ok = 1'b0;
				fin_value = '0;
			end
		endcase
		res_in.ok = fin_ok;
		res_in.value = fin_ok ? fin_value : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			frac_q <= '0;
			td_q <= '0;
			dbp_q <= '0;
			dap_q <= '0;
			point_q <= 1'b0;
			rej_q <= 1'b0;
		end else begin
			acc_q <= acc_n;
			frac_q <= frac_n;
			td_q <= td_n;
			dbp_q <= dbp_n;
			dap_q <= dap_n;
			point_q <= point_n;
			rej_q <= rej_n;
		end
	end

	// result queue
	always_ff @(posedge clk) begin
		if (res_push) begin
			res_q[res_wr_q] <= res_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_cnt_q <= 2'd0;
			res_wr_q <= 1'b0;
			res_rd_q <= 1'b0;
		end else begin
			if (res_push) res_wr_q <= !res_wr_q;
			if (res_pop) res_rd_q <= !res_rd_q;
			case ({res_push, res_pop})
				2'b10: res_cnt_q <= res_cnt_q + 2'd1;
				2'b01: res_cnt_q <= res_cnt_q - 2'd1;
				default: res_cnt_q <= res_cnt_q;
			endcase
		end
	end

	assign empty = (res_cnt_q == 2'd0);
	assign text_ok = res_q[res_rd_q].ok;
	assign field_value = res_q[res_rd_q].value;

`ifndef SYNTH
	a_res_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_cnt_q != 2'd3)
		else $error("result queue count out of range");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_full |-> !res_push)
		else $error("result pushed into a full queue");

	a_clear_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |=> (acc_q == '0 && td_q == '0 && !rej_q && !point_q))
		else $error("parse state not cleared after end of text");

	a_invalid_gives_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !text_ok) |-> field_value == '0)
		else $error("rejected text carries a nonzero value");
`endif

endmodule

// ----- rtl/decimal_text_field_parser.sv -----
// decimal_text_field_parser: top level of the decimal text field parser
// depends on dtfp_pkg, dtfp_front and dtfp_back
//
// usage:
//  - input side is a queue: drive mode, char_code and end_of_text with push
//    high; the request is taken at a clock edge where full is low
//  - each character updates the running parse; an end-of-text request
//    produces one result (text_ok, field_value) and clears the parse state
//  - result side is a queue: while empty is low the oldest result sits on
//    text_ok/field_value and is taken at an edge where pop is high
//  - throughput is one request per cycle while full is low; an accepted
//    end-of-text request passes through one front queue slot, then the back
//    end evaluates it and writes the result queue, and empty goes low
//  - two-entry queues sit in front of the back end and on the result side;
//    with a stalled receiver characters keep flowing until an end-of-text
//    request meets two waiting results, then it holds at the head of the
//    front queue and full rises once one more request queues behind it
//  - the user writes limit registers through cfg_wr_en/cfg_addr/cfg_wdata only
//    while the block is idle, not enforced; reset loads default limits, clears all state
module decimal_text_field_parser import dtfp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic [1:0]            mode,
	input  logic [7:0]            char_code,
	input  logic                  end_of_text,
	output logic                  empty,
	input  logic                  pop,
	output logic                  text_ok,
	output logic [VALUE_W-1:0]    field_value,
	input  logic                  cfg_wr_en,
	input  logic                  cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	cfg_t  cfg_q;
	logic  mid_valid;
	item_t mid_item;
	logic  mid_pop;

	// limit registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.money_limit <= MONEY_LIMIT_RST;
			cfg_q.volume_limit_cl <= VOLUME_LIMIT_RST;
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				REG_MONEY_LIMIT: cfg_q.money_limit <= cfg_wdata[MONEY_W-1:0];
				REG_VOLUME_LIMIT: cfg_q.volume_limit_cl <= cfg_wdata[VOL_W-1:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	// front: classify characters and buffer them
	dtfp_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.mode        (mode),
		.char_code   (char_code),
		.end_of_text (end_of_text),
		.full        (full),
		.mid_valid   (mid_valid),
		.mid_item    (mid_item),
		.mid_pop     (mid_pop)
	);

	// back: parse state, end-of-text checks, result queue
	dtfp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.mid_valid    (mid_valid),
		.mid_item     (mid_item),
		.mid_pop      (mid_pop),
		.empty        (empty),
		.pop          (pop),
		.text_ok      (text_ok),
		.field_value  (field_value)
	);

endmodule
